// ===== sv/tdm_pkg.sv =====
package tdm_pkg;

  localparam int unsigned VelW   = 16;  // Q3.12 twist fields
  localparam int unsigned TimeW  = 20;  // elapsed time, 2^-20 s
  localparam int unsigned CmdW   = 16;  // Q1.14 track commands
  localparam int unsigned MulAW  = 21;  // shared multiplier, signed operand A
  localparam int unsigned MulBW  = 17;  // shared multiplier, signed operand B
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned SideW  = 19;  // side velocity, Q.12
  localparam int unsigned RawW   = 26;  // raw side command, Q1.14 unbounded
  localparam int unsigned DivQW  = 15;  // scaled quotient, at most 16384
  localparam int unsigned OneSh  = 14;  // Q1.14 binary point
  localparam int unsigned DivW   = RawW + OneSh;
  localparam int unsigned StepW  = 17;  // slew step, at most 32768
  localparam int unsigned StepMax = 32768;
  localparam int unsigned OneQ14 = 16384;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    MUL_SPOT,
    MUL_TURN,
    MUL_LEFT,
    MUL_RIGHT,
    MUL_STEP
  } mul_sel_e;

  typedef struct packed {
    logic [14:0] threshold;
    logic [15:0] bias;
    logic [15:0] gain;
    logic [15:0] half_track;
    logic [14:0] deadband;
    logic [15:0] ramp;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     spot_upd;
    logic     side_upd;
    logic     raw_l_upd;
    logic     raw_r_upd;
    logic     step_upd;
    logic     max_upd;
    logic     div_load;
    logic     div_side;
    logic     div_step;
    logic     div_store;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic scale;
  } sts_t;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [ProdW-1:0] round_shr(input logic signed [ProdW-1:0] p,
                                                        input int unsigned sh);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] r;
    mag = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
    r = (mag + (ProdW'(1) << (sh - 1))) >> sh;
    return p[ProdW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ===== sv/track_drive_mixer.sv =====
// Track drive mixer: turns one twist request (linear_vel_i, angular_vel_i,
// both Q3.12) plus elapsed_time_i into left/right track commands in Q1.14.
// Input channel: in_valid_i/in_ready_o; output channel: out_valid_o/out_ready_i.
// Registers sit on an APB port (psel ... pready), one 32-bit word per register.
// Flow: one request at a time. When either side exceeds one, both sides are
// scaled down by the larger magnitude in the shared restoring divider, one
// side after the other. in_ready_o rises together with out_valid_o. The pace
// is set by the single shared 21x17 multiplier that runs five products in turn
// and by the one-bit-per-cycle divider.
// Reset loads the register defaults and clears the previous side commands
// that the slew limit works from.
// A stalled receiver holds the result in the output register; the next request
// is still taken and worked on, and waits at its last step until the output
// register frees up.
module track_drive_mixer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [tdm_pkg::VelW-1:0]  linear_vel_i,
  input  logic signed [tdm_pkg::VelW-1:0]  angular_vel_i,
  input  logic        [tdm_pkg::TimeW-1:0] elapsed_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tdm_pkg::CmdW-1:0]  left_cmd_o,
  output logic signed [tdm_pkg::CmdW-1:0]  right_cmd_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic        [tdm_pkg::AddrW-1:0] paddr,
  input  logic        [tdm_pkg::DataW-1:0] pwdata,
  output logic        [tdm_pkg::DataW-1:0] prdata,
  output logic                             pready
);
  import tdm_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tdm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tdm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .linear_vel_i   (linear_vel_i),
    .angular_vel_i  (angular_vel_i),
    .elapsed_time_i (elapsed_time_i),
    .sts_o          (sts),
    .left_cmd_o     (left_cmd_o),
    .right_cmd_o    (right_cmd_o)
  );

endmodule

// ===== sv/tdm_regs.sv =====
module tdm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tdm_pkg::AddrW-1:0]  paddr,
  input  logic [tdm_pkg::DataW-1:0]  pwdata,
  output logic [tdm_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output tdm_pkg::cfg_t              cfg_o
);
  import tdm_pkg::*;

  typedef enum logic [2:0] {
    REG_THRESHOLD,
    REG_BIAS,
    REG_GAIN,
    REG_HALF_TRACK,
    REG_DEADBAND,
    REG_RAMP
  } reg_idx_e;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= 15'd82;
      cfg_q.bias       <= 16'd4096;
      cfg_q.gain       <= 16'd4967;
      cfg_q.half_track <= 16'd5571;
      cfg_q.deadband   <= 15'd328;
      cfg_q.ramp       <= 16'd512;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD:  cfg_q.threshold  <= pwdata[14:0];
        REG_BIAS:       cfg_q.bias       <= pwdata[15:0];
        REG_GAIN:       cfg_q.gain       <= pwdata[15:0];
        REG_HALF_TRACK: cfg_q.half_track <= pwdata[15:0];
        REG_DEADBAND:   cfg_q.deadband   <= pwdata[14:0];
        REG_RAMP:       cfg_q.ramp       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD:  prdata = DataW'(cfg_q.threshold);
      REG_BIAS:       prdata = DataW'(cfg_q.bias);
      REG_GAIN:       prdata = DataW'(cfg_q.gain);
      REG_HALF_TRACK: prdata = DataW'(cfg_q.half_track);
      REG_DEADBAND:   prdata = DataW'(cfg_q.deadband);
      REG_RAMP:       prdata = DataW'(cfg_q.ramp);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/tdm_ctrl.sv =====
module tdm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  tdm_pkg::sts_t  sts_i,
  output tdm_pkg::cmd_t  cmd_o
);
  import tdm_pkg::*;

  localparam int unsigned CntW = $clog2(DivQW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivQW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPOT,
    S_SPOTW,
    S_TURN,
    S_SIDE,
    S_MUL_L,
    S_MUL_R,
    S_STEP,
    S_MAX,
    S_CHK,
    S_DLOAD,
    S_DIV,
    S_DSTORE,
    S_FIN
  } state_e;

  state_e          state_q, state_d;
  logic            in_ready_q, in_ready_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            side_q, side_d;
  logic            out_free;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    side_d      = side_q;
    cmd_o       = '0;
    cmd_o.mul_sel  = MUL_SPOT;
    cmd_o.div_side = side_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load = 1'b1;
          in_ready_d = 1'b0;
          state_d    = S_SPOT;
        end
      end
      S_SPOT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPOT;
        state_d       = S_SPOTW;
      end
      S_SPOTW: begin
        cmd_o.spot_upd = 1'b1;
        state_d        = S_TURN;
      end
      S_TURN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_TURN;
        state_d       = S_SIDE;
      end
      S_SIDE: begin
        cmd_o.side_upd = 1'b1;
        state_d        = S_MUL_L;
      end
      S_MUL_L: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LEFT;
        state_d       = S_MUL_R;
      end
      S_MUL_R: begin
        cmd_o.raw_l_upd = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_RIGHT;
        state_d         = S_STEP;
      end
      S_STEP: begin
        cmd_o.raw_r_upd = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_STEP;
        state_d         = S_MAX;
      end
      S_MAX: begin
        cmd_o.step_upd = 1'b1;
        cmd_o.max_upd  = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        side_d  = 1'b0;
        state_d = sts_i.scale ? S_DLOAD : S_FIN;
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_DSTORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DSTORE: begin
        cmd_o.div_store = 1'b1;
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = S_DLOAD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          in_ready_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      side_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      side_q      <= side_d;
    end
  end

endmodule

// ===== sv/tdm_dp.sv =====
module tdm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tdm_pkg::cmd_t                       cmd_i,
  input  tdm_pkg::cfg_t                       cfg_i,
  input  logic signed [tdm_pkg::VelW-1:0]     linear_vel_i,
  input  logic signed [tdm_pkg::VelW-1:0]     angular_vel_i,
  input  logic        [tdm_pkg::TimeW-1:0]    elapsed_time_i,
  output tdm_pkg::sts_t                       sts_o,
  output logic signed [tdm_pkg::CmdW-1:0]     left_cmd_o,
  output logic signed [tdm_pkg::CmdW-1:0]     right_cmd_o
);
  import tdm_pkg::*;

  localparam logic signed [ProdW-1:0] SatHi = ProdW'(2**(VelW-1) - 1);
  localparam logic signed [ProdW-1:0] SatLo = -ProdW'(2**(VelW-1));

  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [ProdW-1:0] x);
    logic signed [VelW-1:0] r;
    if (x > SatHi) begin
      r = SatHi[VelW-1:0];
    end else if (x < SatLo) begin
      r = SatLo[VelW-1:0];
    end else begin
      r = x[VelW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CmdW-1:0] dead_zone(input logic signed [CmdW-1:0] x,
                                                        input logic [14:0] db);
    logic [CmdW-1:0] mag;
    mag = x[CmdW-1] ? CmdW'(-x) : CmdW'(x);
    return (mag < CmdW'(db)) ? '0 : x;
  endfunction

  // Clamp target to prev plus or minus step.
  function automatic logic signed [CmdW-1:0] slew_lim(input logic signed [CmdW-1:0] tgt,
                                                       input logic signed [CmdW-1:0] prv,
                                                       input logic [StepW-1:0] st);
    logic signed [StepW:0] t;
    logic signed [StepW:0] p;
    logic signed [StepW:0] s;
    logic signed [StepW:0] lo;
    logic signed [StepW:0] hi;
    logic signed [CmdW-1:0] r;
    t  = (StepW+1)'(tgt);
    p  = (StepW+1)'(prv);
    s  = $signed({1'b0, st});
    lo = p - s;
    hi = p + s;
    if (t < lo) begin
      r = lo[CmdW-1:0];
    end else if (t > hi) begin
      r = hi[CmdW-1:0];
    end else begin
      r = tgt;
    end
    return r;
  endfunction

  logic signed [VelW-1:0]  v_q, w_q;
  logic        [TimeW-1:0] dt_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [SideW-1:0] vl_q, vr_q;
  logic signed [RawW-1:0]  ul_q, ur_q;
  logic        [RawW-1:0]  m_q;
  logic        [StepW-1:0] step_q;
  logic signed [CmdW-1:0]  l_q, r_q;
  logic        [DivW-1:0]  rem_q, dsr_q;
  logic        [DivQW-1:0] quo_q;
  logic signed [CmdW-1:0]  prev_l_q, prev_r_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [VelW:0]    v_ext;
  logic        [VelW:0]    v_mag;
  logic                    spot_hit;
  logic signed [SideW-1:0] turn;
  logic signed [SideW-1:0] v_side;
  logic        [RawW-1:0]  ul_mag, ur_mag, div_mag;
  logic        [ProdW-1:0] st_r;
  logic signed [CmdW-1:0]  q_ext, div_val;
  logic                    div_neg;
  logic signed [CmdW-1:0]  l_db, r_db;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_SPOT: begin
        mul_a = MulAW'(w_q);
        mul_b = MulBW'(cfg_i.bias);
      end
      MUL_TURN: begin
        mul_a = MulAW'(w_q);
        mul_b = MulBW'(cfg_i.half_track);
      end
      MUL_LEFT: begin
        mul_a = MulAW'(vl_q);
        mul_b = MulBW'(cfg_i.gain);
      end
      MUL_RIGHT: begin
        mul_a = MulAW'(vr_q);
        mul_b = MulBW'(cfg_i.gain);
      end
      MUL_STEP: begin
        mul_a = MulAW'(dt_q);
        mul_b = MulBW'(cfg_i.ramp);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign v_ext    = (VelW+1)'(v_q);
  assign v_mag    = v_ext[VelW] ? -v_ext : v_ext;
  assign spot_hit = v_mag < (VelW+1)'(cfg_i.threshold);

  assign turn   = SideW'(round_shr(prod_q, OneSh));
  assign v_side = SideW'(v_q);

  assign ul_mag  = ul_q[RawW-1] ? -ul_q : ul_q;
  assign ur_mag  = ur_q[RawW-1] ? -ur_q : ur_q;
  assign div_mag = cmd_i.div_side ? ur_mag : ul_mag;

  assign st_r = round_shr(prod_q, OneSh);

  assign q_ext   = $signed(CmdW'(quo_q));
  assign div_neg = cmd_i.div_side ? ur_q[RawW-1] : ul_q[RawW-1];
  assign div_val = div_neg ? -q_ext : q_ext;

  assign l_db = dead_zone(l_q, cfg_i.deadband);
  assign r_db = dead_zone(r_q, cfg_i.deadband);

  assign sts_o.scale = m_q > RawW'(OneQ14);
  assign left_cmd_o  = prev_l_q;
  assign right_cmd_o = prev_r_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= linear_vel_i;
      w_q  <= angular_vel_i;
      dt_q <= elapsed_time_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod;
    end
    if (cmd_i.spot_upd && spot_hit) begin
      v_q <= '0;
      w_q <= sat_vel(round_shr(prod_q, 12));
    end
    if (cmd_i.side_upd) begin
      vl_q <= v_side - turn;
      vr_q <= v_side + turn;
    end
    if (cmd_i.raw_l_upd) begin
      ul_q <= RawW'(round_shr(prod_q, 10));
    end
    if (cmd_i.raw_r_upd) begin
      ur_q <= RawW'(round_shr(prod_q, 10));
    end
    if (cmd_i.step_upd) begin
      step_q <= (st_r > ProdW'(StepMax)) ? StepW'(StepMax) : StepW'(st_r);
    end
    if (cmd_i.max_upd) begin
      m_q <= (ul_mag > ur_mag) ? ul_mag : ur_mag;
      l_q <= CmdW'(ul_q);
      r_q <= CmdW'(ur_q);
    end
    // restoring division of mag * 2^14 + m/2 by m, one quotient bit per cycle
    if (cmd_i.div_load) begin
      rem_q <= (DivW'(div_mag) << OneSh) + DivW'(m_q >> 1);
      dsr_q <= DivW'(m_q) << (DivQW - 1);
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[DivQW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[DivQW-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_side) begin
        r_q <= div_val;
      end else begin
        l_q <= div_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else if (cmd_i.finish) begin
      prev_l_q <= slew_lim(l_db, prev_l_q, step_q);
      prev_r_q <= slew_lim(r_db, prev_r_q, step_q);
    end
  end

endmodule

// ===== sv/tdm_checker.sv =====
module tdm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [tdm_pkg::CmdW-1:0]  left_cmd_o,
  input logic signed [tdm_pkg::CmdW-1:0]  right_cmd_o
);
  import tdm_pkg::*;

  localparam logic signed [CmdW-1:0] CmdHi = CmdW'(OneQ14);
  localparam logic signed [CmdW-1:0] CmdLo = -CmdW'(OneQ14);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_cmd_o) && $stable(right_cmd_o))
    else $error("stalled result changed");

  // results stay within plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_cmd_o >= CmdLo && left_cmd_o <= CmdHi &&
                    right_cmd_o >= CmdLo && right_cmd_o <= CmdHi)
    else $error("track command out of range");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a new result frees the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result without input ready");

endmodule

bind track_drive_mixer tdm_checker u_tdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .left_cmd_o  (left_cmd_o),
  .right_cmd_o (right_cmd_o)
);
